// ===== src/lsh_pkg.sv =====
// shared types and constants for the 3x3 laplacian sharpening filter
// no dependencies; imported by lsh_ctrl, lsh_window, lsh_arith and the top level
`default_nettype none

package lsh_pkg;

	// configuration register map
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;

	localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd3;

	// register widths
	localparam int GAIN_BITS    = 12;
	localparam int IWIDTH_BITS  = 11;
	localparam int IHEIGHT_BITS = 13;

	// reset values
	localparam logic                    KERNEL_RST = 1'b1;
	localparam logic [GAIN_BITS-1:0]    GAIN_RST   = 12'd256;
	localparam logic [IWIDTH_BITS-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [IHEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;

	// frame height limit and row counter width
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_BITS   = 12;

	// smallest legal frame side
	localparam int MIN_SIDE = 3;

	// kernel select codes
	localparam logic KERNEL_4N = 1'b0;
	localparam logic KERNEL_8N = 1'b1;

	// request kinds
	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_t;

	// per-request control that rides along the pipeline
	typedef struct packed {
		logic emit;
		logic border;
		logic last;
	} lsh_flags_t;

endpackage

`default_nettype wire

// ===== src/lsh_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module lsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/lsh_ctrl.sv =====
// input and output raster position counters, pending result count
// depends on lsh_pkg
`default_nettype none

module lsh_ctrl #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               accept,
	input  wire logic                               req_type,
	input  wire logic [$clog2(MAX_WIDTH+2)-1:0]     eff_width,
	input  wire logic [lsh_pkg::IHEIGHT_BITS-1:0]   eff_height,
	output logic                                    push,
	output logic      [$clog2(MAX_WIDTH)-1:0]       col,
	output lsh_pkg::lsh_flags_t                     flags
);

	import lsh_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 2);
	localparam int HW = IHEIGHT_BITS;
	localparam int RW = ROW_BITS;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [WW-1:0] pending_q;

	logic is_drain;
	logic owed;
	logic full;
	logic emit;
	logic flush;
	logic col_wrap;
	logic row_wrap;
	logic out_col_wrap;
	logic out_row_wrap;
	logic out_col_edge;
	logic out_row_edge;

	always_comb begin
		is_drain     = req_type == REQ_DRAIN;
		owed         = pending_q != '0;
		full         = pending_q >= eff_width + WW'(1);
		push         = accept && (!is_drain || owed);
		emit         = accept && (is_drain ? owed : full);
		flush        = accept && is_drain && (pending_q == WW'(1));
		col_wrap     = (WW'(col_q) + WW'(1)) >= eff_width;
		row_wrap     = (HW'(row_q) + HW'(1)) >= eff_height;
		out_col_wrap = (WW'(out_col_q) + WW'(1)) >= eff_width;
		out_row_wrap = (HW'(out_row_q) + HW'(1)) >= eff_height;
		out_col_edge = WW'(out_col_q) >= eff_width - WW'(1);
		out_row_edge = HW'(out_row_q) >= eff_height - HW'(1);
		col          = col_q;
		flags.emit   = emit;
		flags.border = (out_row_q == '0) || (out_col_q == '0) || out_col_edge || out_row_edge;
		flags.last   = out_col_edge && out_row_edge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else begin
			if (flush) begin
				// last pending result flushed: next frame starts fresh
				col_q     <= '0;
				row_q     <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (push) begin
					if (col_wrap) begin
						col_q <= '0;
						row_q <= row_wrap ? '0 : row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				if (emit) begin
					if (out_col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_wrap ? '0 : out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
			if (accept) begin
				if (!is_drain) begin
					pending_q <= full ? eff_width + WW'(1) : pending_q + WW'(1);
				end else if (owed) begin
					pending_q <= pending_q - WW'(1);
				end
			end
		end
	end

	a_flush_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_drain && pending_q == WW'(1)) |=>
		(col_q == '0 && out_col_q == '0 && pending_q == '0))
		else $error("flush did not return positions to origin");

	a_emit_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> push)
		else $error("result produced without a pixel entering the window");

	a_idle_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_drain && pending_q == '0) |=> (pending_q == '0 && $stable(col_q)))
		else $error("drain with nothing pending changed state");

endmodule

`default_nettype wire

// ===== src/lsh_window.sv =====
// line stores and 3x3 window: stage 1 reads the stores, stage 2 holds the window
// depends on lsh_pkg and lsh_ram
`default_nettype none

module lsh_window #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	input  wire logic [PIXEL_BITS-1:0]             pixel,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]      col,
	input  wire lsh_pkg::lsh_flags_t               flags,
	output logic                                   ready_s1,
	input  wire logic                              ready_s3,
	output logic                                   win_valid,
	output logic      [8:0][PIXEL_BITS-1:0]        win,
	output lsh_pkg::lsh_flags_t                    win_flags
);

	import lsh_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic                  v_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         col_s1;
	lsh_flags_t            flags_s1;

	logic                  v_s2;
	lsh_flags_t            flags_s2;
	logic [8:0][PIXEL_BITS-1:0] win_s2;

	logic [PIXEL_BITS-1:0] top_rd;
	logic [PIXEL_BITS-1:0] mid_rd;
	logic                  ready_s2;
	logic                  adv_s1;

	always_comb begin
		ready_s2  = !v_s2 || !flags_s2.emit || ready_s3;
		ready_s1  = !v_s1 || ready_s2;
		adv_s1    = v_s1 && ready_s2;
		win_valid = v_s2 && flags_s2.emit;
		win       = win_s2;
		win_flags = flags_s2;
	end

	// row two back; refilled from the row one back
	lsh_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_top_row (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(col_s1),
		.wdata(mid_rd),
		.re   (push),
		.raddr(col),
		.rdata(top_rd)
	);

	// row one back; refilled from the incoming pixel
	lsh_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_mid_row (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (push),
		.raddr(col),
		.rdata(mid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			flags_s1 <= '0;
			flags_s2 <= '0;
			win_s2   <= '0;
		end else begin
			if (ready_s1) begin
				v_s1 <= push;
				if (push) begin
					flags_s1 <= flags;
				end
			end
			if (adv_s1) begin
				v_s2     <= 1'b1;
				flags_s2 <= flags_s1;
				// shift each row left, new column enters on the right
				win_s2[0] <= win_s2[1];
				win_s2[1] <= win_s2[2];
				win_s2[2] <= top_rd;
				win_s2[3] <= win_s2[4];
				win_s2[4] <= win_s2[5];
				win_s2[5] <= mid_rd;
				win_s2[6] <= win_s2[7];
				win_s2[7] <= win_s2[8];
				win_s2[8] <= pix_s1;
			end else if (ready_s2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && push) begin
			pix_s1 <= pixel;
			col_s1 <= col;
		end
	end

	a_read_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready_s1)
		else $error("line store read issued while stage 1 is held");

	a_window_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(win_valid && !ready_s3) |=> (win_valid && $stable(win_s2)))
		else $error("window changed under a stalled result");

endmodule

`default_nettype wire

// ===== src/lsh_arith.sv =====
// sharpening arithmetic: laplacian sum, gain products, round and clamp
// depends on lsh_pkg
`default_nettype none

module lsh_arith #(
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            win_valid,
	input  wire logic [8:0][PIXEL_BITS-1:0]      win,
	input  wire lsh_pkg::lsh_flags_t             win_flags,
	input  wire logic                            kernel_type,
	input  wire logic [lsh_pkg::GAIN_BITS-1:0]   gain,
	output logic                                 ready_s3,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [PIXEL_BITS-1:0]           pixel_out,
	output logic                                 frame_last
);

	import lsh_pkg::*;

	localparam int PB  = PIXEL_BITS;
	localparam int GB  = GAIN_BITS;
	localparam int SW  = PB + 3;
	localparam int LW  = PB + 4;
	localparam int P1W = 2 * GB + PB;
	localparam int P2W = GB + 1 + LW;
	localparam int XW  = 2 * GB + PB + 3;
	localparam logic [PB-1:0] PIX_MAX = {PB{1'b1}};
	localparam logic [XW-1:0] ROUND_HALF = XW'(32768);

	logic [2*GB-1:0] gg_q;

	logic                 v_s3;
	logic [PB-1:0]        c_s3;
	logic signed [LW-1:0] lap_s3;
	logic                 border_s3;
	logic                 last_s3;

	logic                  v_s4;
	logic [PB-1:0]         c_s4;
	logic [P1W-1:0]        p1_s4;
	logic signed [P2W-1:0] p2_s4;
	logic                  border_s4;
	logic                  last_s4;

	logic ready_s4;
	logic ready_s5;

	logic [SW-1:0]        nb;
	logic [SW-1:0]        kc;
	logic signed [LW-1:0] lap;
	logic [P1W-1:0]       p1;
	logic signed [P2W-1:0] p2;
	logic signed [XW-1:0] xs;
	logic [PB-1:0]        res;

	always_comb begin
		ready_s5 = !out_valid || out_ready;
		ready_s4 = !v_s4 || ready_s5;
		ready_s3 = !v_s3 || ready_s4;

		// edge neighbours, corners only for the 8-neighbour kernel
		nb = SW'(win[1]) + SW'(win[7]) + SW'(win[3]) + SW'(win[5]);
		if (kernel_type == KERNEL_8N) begin
			nb = nb + SW'(win[0]) + SW'(win[2]) + SW'(win[6]) + SW'(win[8]);
			kc = {win[4], 3'b000};
		end else begin
			kc = {1'b0, win[4], 2'b00};
		end
		lap = $signed({1'b0, kc}) - $signed({1'b0, nb});

		p1 = gg_q * c_s3;
		p2 = $signed({1'b0, gain}) * lap_s3;

		xs = $signed(XW'({c_s4, 16'd0})) + $signed(XW'(p1_s4)) +
			(XW'(p2_s4) <<< 8) + $signed(ROUND_HALF);
		if (border_s4) begin
			res = c_s4;
		end else if (xs[XW-1]) begin
			res = '0;
		end else if (|xs[XW-2:PB+16]) begin
			res = PIX_MAX;
		end else begin
			res = xs[PB+15:16];
		end
	end

	// gain squared, constant while frames run
	always_ff @(posedge clk) begin
		gg_q <= gain * gain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= win_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
			if (ready_s5) begin
				out_valid <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && win_valid) begin
			c_s3      <= win[4];
			lap_s3    <= lap;
			border_s3 <= win_flags.border;
			last_s3   <= win_flags.last;
		end
		if (ready_s4 && v_s3) begin
			c_s4      <= c_s3;
			p1_s4     <= p1;
			p2_s4     <= p2;
			border_s4 <= border_s3;
			last_s4   <= last_s3;
		end
		if (ready_s5 && v_s4) begin
			pixel_out  <= res;
			frame_last <= last_s4;
		end
	end

	a_border_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && ready_s5 && border_s4) |=> (pixel_out == $past(c_s4)))
		else $error("border pixel was altered");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !ready_s5) |=> (v_s4 && out_valid))
		else $error("result dropped under backpressure");

endmodule

`default_nettype wire

// ===== src/laplacian_sharpen_3x3.sv =====
// top level of the 3x3 laplacian sharpening filter
// depends on lsh_pkg, lsh_ctrl, lsh_window, lsh_arith and lsh_ram
`default_nettype none

// Sharpens a raster stream of grayscale pixels with a 3x3 laplacian kernel
// (4-neighbour or 8-neighbour, chosen by kernel_type) scaled by an unsigned
// Q4.8 gain, rounding half up and clamping to the pixel range; pixels on the
// frame border pass unchanged. The block takes one request per clock while
// in_ready is high and gives at most one result per clock: a pixel request
// yields the result for the pixel image_width+1 requests earlier once that
// many are owed, and a drain request pushes a zero pixel and flushes one
// owed result, returning all positions to the frame origin once nothing is
// owed. Past the request count, the line store read, the window shift, the
// laplacian sum, the two gain multiplies and the final add, round and clamp
// each take one register stage, in that order. The two line stores are
// single-write, single-read rams of MAX_WIDTH pixels each; they need no
// clearing after reset, since unwritten entries only reach border positions.
// Width and height are clamped to 3..MAX_WIDTH and 3..4096.
// Configuration must only be written while the pipeline is empty.
module laplacian_sharpen_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               req_type,
	input  wire logic [PIXEL_BITS-1:0]              pixel_in,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [PIXEL_BITS-1:0]              pixel_out,
	output logic                                    frame_last,
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [lsh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [lsh_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import lsh_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 2);
	localparam int HW = IHEIGHT_BITS;

	// configuration registers
	logic                    kernel_q;
	logic [GAIN_BITS-1:0]    gain_q;
	logic [IWIDTH_BITS-1:0]  width_q;
	logic [IHEIGHT_BITS-1:0] height_q;

	// clamped frame size
	logic [WW-1:0] eff_width;
	logic [HW-1:0] eff_height;

	// request side
	logic                  accept;
	logic                  push;
	logic [CW-1:0]         col;
	lsh_flags_t            flags;
	logic [PIXEL_BITS-1:0] pixel_eff;

	// window to arithmetic
	logic                       ready_s3;
	logic                       win_valid;
	logic [8:0][PIXEL_BITS-1:0] win;
	lsh_flags_t                 win_flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= KERNEL_RST;
			gain_q   <= GAIN_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KERNEL: kernel_q <= cfg_data[0];
				CFG_GAIN:   gain_q   <= cfg_data[GAIN_BITS-1:0];
				CFG_WIDTH:  width_q  <= cfg_data[IWIDTH_BITS-1:0];
				CFG_HEIGHT: height_q <= cfg_data[IHEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// width clamped to 3..MAX_WIDTH
		if (32'(width_q) < MIN_SIDE) begin
			eff_width = WW'(MIN_SIDE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_width = WW'(MAX_WIDTH);
		end else begin
			eff_width = WW'(width_q);
		end
		// height clamped to 3..4096
		if (32'(height_q) < MIN_SIDE) begin
			eff_height = HW'(MIN_SIDE);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_height = HW'(MAX_HEIGHT);
		end else begin
			eff_height = height_q;
		end

		accept = in_valid && in_ready;
		// a drain request feeds a zero pixel into the window
		pixel_eff = (req_type == REQ_DRAIN) ? '0 : pixel_in;
	end

	// raster positions and owed-result bookkeeping
	lsh_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.eff_width (eff_width),
		.eff_height(eff_height),
		.push      (push),
		.col       (col),
		.flags     (flags)
	);

	// line stores and window registers
	lsh_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pixel    (pixel_eff),
		.col      (col),
		.flags    (flags),
		.ready_s1 (in_ready),
		.ready_s3 (ready_s3),
		.win_valid(win_valid),
		.win      (win),
		.win_flags(win_flags)
	);

	// kernel sum, gain and output register
	lsh_arith #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_arith (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (win_valid),
		.win        (win),
		.win_flags  (win_flags),
		.kernel_type(kernel_q),
		.gain       (gain_q),
		.ready_s3   (ready_s3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

	a_size_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(eff_width) >= MIN_SIDE) && (32'(eff_width) <= MAX_WIDTH) &&
		(32'(eff_height) >= MIN_SIDE) && (32'(eff_height) <= MAX_HEIGHT))
		else $error("effective frame size out of range");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before it was taken");

	// a stalled window with a request just taken into stage 1 leaves no room
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(win_valid && !ready_s3 && push) |=> (ready_s3 || !in_ready))
		else $error("request taken while the pipeline is full");

endmodule

`default_nettype wire
